>>> hdl/stroke_bevel_join_vertices_defines.svh
// ----------------------------------------------------------------------------
// stroke bevel join vertices: assertion macros
// shared concurrent assertion forms for the join vertex generator
// ----------------------------------------------------------------------------
`ifndef STROKE_BEVEL_JOIN_VERTICES_DEFINES_SVH
`define STROKE_BEVEL_JOIN_VERTICES_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SBJ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbj assertion failed");

// next-cycle implication, disabled while reset is high
`define SBJ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbj assertion failed");

`endif

>>> hdl/sbj_pkg.sv
// ----------------------------------------------------------------------------
// sbj_pkg
// types, constants and the vertex order table of the join vertex generator
// ----------------------------------------------------------------------------
`default_nettype none

package sbj_pkg;

   localparam int COORD_W = 32;
   localparam int DIR_W   = 18;
   localparam int WIDTH_W = 25;
   localparam int U_W     = 17;
   localparam int FRAC_W  = 16;
   localparam int WMUL_W  = WIDTH_W + 1;
   localparam int PROD_W  = COORD_W + WMUL_W;
   localparam int SUM_W   = PROD_W - FRAC_W + 1;
   localparam int CNT_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] VERTS_BEVEL = CNT_W'(8);
   localparam logic [CNT_W-1:0] VERTS_MITER = CNT_W'(10);

   localparam logic [U_W-1:0] HALF_U = U_W'(32768);

   localparam logic signed [1:0] SIDE_NEG = 2'sb11;
   localparam logic signed [1:0] SIDE_POS = 2'sb01;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WIDTH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_U      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_U     = CSR_IDX_W'(3);

   // which point of the join a vertex sits on
   typedef enum logic [2:0] {
      PT_L0,   // left edge, incoming segment
      PT_L1,   // left edge, outgoing segment
      PT_R0,   // right edge, incoming segment
      PT_R1,   // right edge, outgoing segment
      PT_QL,   // miter tip on the left
      PT_QR,   // miter tip on the right
      PT_CTR   // join point itself
   } vtx_pt_type;

   typedef struct packed {
      vtx_pt_type pt;
      logic       side_neg;
   } step_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [DIR_W-1:0]   prev_dir_x;
      logic signed [DIR_W-1:0]   prev_dir_y;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [COORD_W-1:0] miter_x;
      logic signed [COORD_W-1:0] miter_y;
      logic                      turns_left;
      logic                      inner_bevel;
      logic                      bevel_join;
   } item_type;

   // one vertex slot leaving the sequencer
   typedef struct packed {
      logic     valid;
      logic     last;
      step_type step;
   } issue_type;

   // one vertex after the offset multiply
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic                      side_neg;
      logic [U_W-1:0]            tex_u;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [PROD_W-1:0]  prod_x;
      logic signed [PROD_W-1:0]  prod_y;
   } prod_type;

   // vertex order of the triangle strip
   function automatic step_type seq_step(input logic tl, input logic bevel,
                                         input logic [CNT_W-1:0] idx);
      step_type s;
      s.pt       = PT_CTR;
      s.side_neg = 1'b1;
      if (bevel) begin
         case (idx[2:1])
            2'd0, 2'd1: s.pt = idx[0] ? PT_R0 : PT_L0;
            default:    s.pt = idx[0] ? PT_R1 : PT_L1;
         endcase
         s.side_neg = idx[0] ^ tl;
      end else if (tl) begin
         case (idx)
            4'd0: begin s.pt = PT_L0;  s.side_neg = 1'b1; end
            4'd1: begin s.pt = PT_R0;  s.side_neg = 1'b0; end
            4'd2: begin s.pt = PT_CTR; s.side_neg = 1'b1; end
            4'd3: begin s.pt = PT_R0;  s.side_neg = 1'b0; end
            4'd4: begin s.pt = PT_QR;  s.side_neg = 1'b1; end
            4'd5: begin s.pt = PT_QR;  s.side_neg = 1'b0; end
            4'd6: begin s.pt = PT_CTR; s.side_neg = 1'b1; end
            4'd7: begin s.pt = PT_R1;  s.side_neg = 1'b0; end
            4'd8: begin s.pt = PT_L1;  s.side_neg = 1'b1; end
            default: begin s.pt = PT_R1; s.side_neg = 1'b0; end
         endcase
      end else begin
         case (idx)
            4'd0: begin s.pt = PT_L0;  s.side_neg = 1'b0; end
            4'd1: begin s.pt = PT_R0;  s.side_neg = 1'b1; end
            4'd2: begin s.pt = PT_L0;  s.side_neg = 1'b0; end
            4'd3: begin s.pt = PT_CTR; s.side_neg = 1'b1; end
            4'd4: begin s.pt = PT_QL;  s.side_neg = 1'b0; end
            4'd5: begin s.pt = PT_QL;  s.side_neg = 1'b1; end
            4'd6: begin s.pt = PT_L1;  s.side_neg = 1'b0; end
            4'd7: begin s.pt = PT_CTR; s.side_neg = 1'b1; end
            4'd8: begin s.pt = PT_L1;  s.side_neg = 1'b0; end
            default: begin s.pt = PT_R1; s.side_neg = 1'b1; end
         endcase
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hdl/sbj_seq.sv
// ----------------------------------------------------------------------------
// sbj_seq
// holds the current join and steps through its vertex slots, one per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "stroke_bevel_join_vertices_defines.svh"

module sbj_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire sbj_pkg::item_type item_in,
   output logic                   busy,
   output sbj_pkg::item_type      item_out,
   output sbj_pkg::issue_type     issue
);

   logic                       active_ff;
   logic [sbj_pkg::CNT_W-1:0]  idx_ff;
   sbj_pkg::item_type          item_ff;
   sbj_pkg::step_type          step;
   logic [sbj_pkg::CNT_W-1:0]  count;
   logic                       last;
   logic                       last_issue;
   logic                       accept;

   assign step  = sbj_pkg::seq_step(item_ff.turns_left, item_ff.bevel_join, idx_ff);
   assign count = item_ff.bevel_join ? sbj_pkg::VERTS_BEVEL : sbj_pkg::VERTS_MITER;
   assign last  = (idx_ff == count - sbj_pkg::CNT_W'(1));

   // next join may load while the last slot of this one issues
   assign last_issue = active_ff && last;
   assign busy       = active_ff && !last_issue;
   assign accept     = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else if (accept) begin
         active_ff <= 1'b1;
         idx_ff    <= '0;
      end else if (last_issue) begin
         active_ff <= 1'b0;
      end else if (active_ff) begin
         idx_ff <= idx_ff + sbj_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_out    = item_ff;
   assign issue.valid = active_ff;
   assign issue.last  = last;
   assign issue.step  = step;

   `SBJ_ASSERT_NEXT(a_load_first, clock, reset, accept, active_ff && idx_ff == '0)
   `SBJ_ASSERT_NEXT(a_no_drop, clock, reset, active_ff && !last && !accept, active_ff)
   `SBJ_ASSERT_NOW(a_idx_range, clock, reset, active_ff, idx_ff < sbj_pkg::VERTS_MITER)
   `SBJ_ASSERT_NEXT(a_step_on, clock, reset, active_ff && !last && !accept,
                    idx_ff == $past(idx_ff) + sbj_pkg::CNT_W'(1))

endmodule

`default_nettype wire

>>> hdl/sbj_mul.sv
// ----------------------------------------------------------------------------
// sbj_mul
// picks the offset coefficients and width of a vertex and multiplies them
// ----------------------------------------------------------------------------
`default_nettype none

module sbj_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sbj_pkg::item_type             item,
   input  wire sbj_pkg::issue_type            issue,
   input  wire logic [sbj_pkg::WIDTH_W-1:0]   left_width,
   input  wire logic [sbj_pkg::WIDTH_W-1:0]   right_width,
   input  wire logic [sbj_pkg::U_W-1:0]       left_u,
   input  wire logic [sbj_pkg::U_W-1:0]       right_u,
   output sbj_pkg::prod_type                  prod
);

   logic use_miter;
   logic use_next;
   logic use_right;
   logic use_zero;
   logic left_miter;
   logic right_miter;

   logic signed [sbj_pkg::COORD_W-1:0] coef_x;
   logic signed [sbj_pkg::COORD_W-1:0] coef_y;
   logic signed [sbj_pkg::WMUL_W-1:0]  w_mag;
   logic signed [sbj_pkg::WMUL_W-1:0]  w_x;
   logic signed [sbj_pkg::WMUL_W-1:0]  w_y;
   logic [sbj_pkg::U_W-1:0]            tex_u;

   logic                  valid_ff;
   sbj_pkg::prod_type     prod_ff;
   sbj_pkg::prod_type     prod_in;

   // inner side is mitered unless inner bevel is asked for
   assign left_miter  = item.turns_left && !item.inner_bevel;
   assign right_miter = !item.turns_left && !item.inner_bevel;

   always_comb begin
      use_miter = 1'b0;
      use_next  = 1'b0;
      use_right = 1'b0;
      use_zero  = 1'b0;
      case (issue.step.pt)
         sbj_pkg::PT_L0: begin
            use_miter = left_miter;
         end
         sbj_pkg::PT_L1: begin
            use_miter = left_miter;
            use_next  = 1'b1;
         end
         sbj_pkg::PT_R0: begin
            use_miter = right_miter;
            use_right = 1'b1;
         end
         sbj_pkg::PT_R1: begin
            use_miter = right_miter;
            use_next  = 1'b1;
            use_right = 1'b1;
         end
         sbj_pkg::PT_QL: begin
            use_miter = 1'b1;
         end
         sbj_pkg::PT_QR: begin
            use_miter = 1'b1;
            use_right = 1'b1;
         end
         default: begin
            use_zero = 1'b1;
         end
      endcase
   end

   // left normal of (dx,dy) is (dy,-dx)
   always_comb begin
      if (use_zero) begin
         coef_x = '0;
         coef_y = '0;
      end else if (use_miter) begin
         coef_x = item.miter_x;
         coef_y = item.miter_y;
      end else if (use_next) begin
         coef_x = sbj_pkg::COORD_W'(item.dir_y);
         coef_y = sbj_pkg::COORD_W'(item.dir_x);
      end else begin
         coef_x = sbj_pkg::COORD_W'(item.prev_dir_y);
         coef_y = sbj_pkg::COORD_W'(item.prev_dir_x);
      end
   end

   assign w_mag = $signed({1'b0, (use_right ? right_width : left_width)});
   assign w_x   = use_right ? -w_mag : w_mag;
   assign w_y   = use_miter ? w_x : -w_x;

   always_comb begin
      if (use_zero) begin
         tex_u = sbj_pkg::HALF_U;
      end else if (use_right) begin
         tex_u = right_u;
      end else begin
         tex_u = left_u;
      end
   end

   assign prod_in.valid    = issue.valid;
   assign prod_in.last     = issue.last;
   assign prod_in.side_neg = issue.step.side_neg;
   assign prod_in.tex_u    = tex_u;
   assign prod_in.point_x  = item.point_x;
   assign prod_in.point_y  = item.point_y;
   assign prod_in.prod_x   = sbj_pkg::PROD_W'(coef_x) * sbj_pkg::PROD_W'(w_x);
   assign prod_in.prod_y   = sbj_pkg::PROD_W'(coef_y) * sbj_pkg::PROD_W'(w_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prod_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      prod       = prod_ff;
      prod.valid = valid_ff;
   end

endmodule

`default_nettype wire

>>> hdl/sbj_sat.sv
// ----------------------------------------------------------------------------
// sbj_sat
// drops the product fraction, adds the join point and saturates the vertex
// ----------------------------------------------------------------------------
`default_nettype none

module sbj_sat (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sbj_pkg::prod_type                   prod,
   output logic                                     rsp_valid,
   output logic signed [sbj_pkg::COORD_W-1:0]       rsp_vert_x,
   output logic signed [sbj_pkg::COORD_W-1:0]       rsp_vert_y,
   output logic [sbj_pkg::U_W-1:0]                  rsp_tex_u,
   output logic signed [1:0]                        rsp_side,
   output logic                                     rsp_last_vertex
);

   logic signed [sbj_pkg::SUM_W-1:0]   sum_x;
   logic signed [sbj_pkg::SUM_W-1:0]   sum_y;
   logic signed [sbj_pkg::COORD_W-1:0] vert_x_in;
   logic signed [sbj_pkg::COORD_W-1:0] vert_y_in;

   logic                               valid_ff;
   logic signed [sbj_pkg::COORD_W-1:0] vert_x_ff;
   logic signed [sbj_pkg::COORD_W-1:0] vert_y_ff;
   logic [sbj_pkg::U_W-1:0]            tex_u_ff;
   logic signed [1:0]                  side_ff;
   logic                               last_ff;

   function automatic logic signed [sbj_pkg::COORD_W-1:0] sat32(
         input logic signed [sbj_pkg::SUM_W-1:0] v);
      logic [sbj_pkg::SUM_W-sbj_pkg::COORD_W:0] top;
      top = v[sbj_pkg::SUM_W-1:sbj_pkg::COORD_W-1];
      if (top == '0 || top == '1) begin
         return v[sbj_pkg::COORD_W-1:0];
      end else if (v[sbj_pkg::SUM_W-1]) begin
         return {1'b1, {(sbj_pkg::COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(sbj_pkg::COORD_W-1){1'b1}}};
      end
   endfunction

   // arithmetic shift floors toward minus infinity
   assign sum_x = sbj_pkg::SUM_W'(prod.point_x)
                + sbj_pkg::SUM_W'(prod.prod_x >>> sbj_pkg::FRAC_W);
   assign sum_y = sbj_pkg::SUM_W'(prod.point_y)
                + sbj_pkg::SUM_W'(prod.prod_y >>> sbj_pkg::FRAC_W);

   assign vert_x_in = sat32(sum_x);
   assign vert_y_in = sat32(sum_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= prod.valid;
      end
   end

   always_ff @(posedge clock) begin
      vert_x_ff <= vert_x_in;
      vert_y_ff <= vert_y_in;
      tex_u_ff  <= prod.tex_u;
      side_ff   <= prod.side_neg ? sbj_pkg::SIDE_NEG : sbj_pkg::SIDE_POS;
      last_ff   <= prod.last;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_vert_x      = vert_x_ff;
   assign rsp_vert_y      = vert_y_ff;
   assign rsp_tex_u       = tex_u_ff;
   assign rsp_side        = side_ff;
   assign rsp_last_vertex = last_ff && valid_ff;

endmodule

`default_nettype wire

>>> hdl/stroke_bevel_join_vertices.sv
// ----------------------------------------------------------------------------
// stroke_bevel_join_vertices
// triangle-strip vertex generator for bevel and miter joins of a stroked path
// ----------------------------------------------------------------------------
// first vertex beat passes the join, product and result registers, then one per cycle
// joins give 8 vertices (bevel) or 10 (miter), paced by the
//   single vertex result port; the next join loads during the last vertex slot
// reset: synchronous, active high; clears the sequencer and pipeline valids and
//   returns widths to 1.0, left u to 0 and right u to 1.0
// results are strobed on rsp_valid for one cycle; the receiver cannot stall
`default_nettype none

module stroke_bevel_join_vertices (
   input  wire logic                                clock,
   input  wire logic                                reset,

   // join input
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [sbj_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [sbj_pkg::COORD_W-1:0]  req_point_y,
   input  wire logic signed [sbj_pkg::DIR_W-1:0]    req_prev_dir_x,
   input  wire logic signed [sbj_pkg::DIR_W-1:0]    req_prev_dir_y,
   input  wire logic signed [sbj_pkg::DIR_W-1:0]    req_dir_x,
   input  wire logic signed [sbj_pkg::DIR_W-1:0]    req_dir_y,
   input  wire logic signed [sbj_pkg::COORD_W-1:0]  req_miter_x,
   input  wire logic signed [sbj_pkg::COORD_W-1:0]  req_miter_y,
   input  wire logic                                req_turns_left,
   input  wire logic                                req_inner_bevel,
   input  wire logic                                req_bevel_join,

   // vertex output
   output logic                                     rsp_valid,
   output logic signed [sbj_pkg::COORD_W-1:0]       rsp_vert_x,
   output logic signed [sbj_pkg::COORD_W-1:0]       rsp_vert_y,
   output logic [sbj_pkg::U_W-1:0]                  rsp_tex_u,
   output logic signed [1:0]                        rsp_side,
   output logic                                     rsp_last_vertex,

   // register write port
   input  wire logic                                csr_write,
   input  wire logic [sbj_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sbj_pkg::WIDTH_W-1:0]         csr_data
);

   // stroke registers
   logic [sbj_pkg::WIDTH_W-1:0] left_width_ff;
   logic [sbj_pkg::WIDTH_W-1:0] right_width_ff;
   logic [sbj_pkg::U_W-1:0]     left_u_ff;
   logic [sbj_pkg::U_W-1:0]     right_u_ff;

   sbj_pkg::item_type  req_item;
   sbj_pkg::item_type  cur_item;
   sbj_pkg::issue_type issue;
   sbj_pkg::prod_type  prod;

   // writes act at once; the host must write only with no join in flight; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         left_width_ff  <= sbj_pkg::WIDTH_W'(65536);
         right_width_ff <= sbj_pkg::WIDTH_W'(65536);
         left_u_ff      <= '0;
         right_u_ff     <= sbj_pkg::U_W'(65536);
      end else if (csr_write) begin
         case (csr_index)
            sbj_pkg::CSR_LEFT_WIDTH:  left_width_ff  <= csr_data;
            sbj_pkg::CSR_RIGHT_WIDTH: right_width_ff <= csr_data;
            sbj_pkg::CSR_LEFT_U:      left_u_ff      <= csr_data[sbj_pkg::U_W-1:0];
            sbj_pkg::CSR_RIGHT_U:     right_u_ff     <= csr_data[sbj_pkg::U_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // gather the input beat
   assign req_item.point_x     = req_point_x;
   assign req_item.point_y     = req_point_y;
   assign req_item.prev_dir_x  = req_prev_dir_x;
   assign req_item.prev_dir_y  = req_prev_dir_y;
   assign req_item.dir_x       = req_dir_x;
   assign req_item.dir_y       = req_dir_y;
   assign req_item.miter_x     = req_miter_x;
   assign req_item.miter_y     = req_miter_y;
   assign req_item.turns_left  = req_turns_left;
   assign req_item.inner_bevel = req_inner_bevel;
   assign req_item.bevel_join  = req_bevel_join;

   // join register and vertex slot counter
   sbj_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item_in  (req_item),
      .busy     (busy),
      .item_out (cur_item),
      .issue    (issue)
   );

   // coefficient and width select, offset products
   sbj_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .item        (cur_item),
      .issue       (issue),
      .left_width  (left_width_ff),
      .right_width (right_width_ff),
      .left_u      (left_u_ff),
      .right_u     (right_u_ff),
      .prod        (prod)
   );

   // floor, add point, saturate, result register
   sbj_sat u_sat (
      .clock           (clock),
      .reset           (reset),
      .prod            (prod),
      .rsp_valid       (rsp_valid),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_side        (rsp_side),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule

`default_nettype wire
